// ===== hdl/rgbhist_pkg.sv =====
// shared constants, codes and types for the rgb cube histogram
package rgbhist_pkg;

    // default build sizes
    localparam int MAX_AXIS_BINS = 16;
    localparam int COUNT_BITS    = 32;

    // field widths
    localparam int FUNC_W      = 2;
    localparam int COLOR_W     = 8;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int INDEX_OUT_W = 12;
    localparam int COUNT_OUT_W = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROB_W      = FRAC_BITS + 1;

    // probability of exactly one in q1.16
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_BITS;

    // bins per axis after reset
    localparam logic [CFG_W-1:0] BIN_RESET = CFG_W'(8);

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RAW   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROB  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;

    // raw bin settings as written
    typedef struct packed {
        logic [CFG_W-1:0] red_split;
        logic [CFG_W-1:0] green_split;
        logic [CFG_W-1:0] blue_split;
    } bins_cfg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_DATA,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

// ===== hdl/rgbhist_if.sv =====
// handshake channels of the rgb cube histogram: pixel items, results, configuration

// pixel item channel
interface rgbhist_pix_if;
    logic                              valid;
    logic                              ready;
    logic [rgbhist_pkg::FUNC_W-1:0]    func;
    logic [rgbhist_pkg::COLOR_W-1:0]   red;
    logic [rgbhist_pkg::COLOR_W-1:0]   green;
    logic [rgbhist_pkg::COLOR_W-1:0]   blue;

    modport source (output valid, func, red, green, blue, input ready);
    modport sink   (input valid, func, red, green, blue, output ready);
endinterface

// result item channel
interface rgbhist_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [rgbhist_pkg::INDEX_OUT_W-1:0]   bin_index;
    logic [rgbhist_pkg::COUNT_OUT_W-1:0]   bin_count;
    logic [rgbhist_pkg::PROB_W-1:0]        probability;
    logic [rgbhist_pkg::COUNT_OUT_W-1:0]   total_pixels;

    modport source (output valid, bin_index, bin_count, probability, total_pixels,
                    input ready);
    modport sink   (input valid, bin_index, bin_count, probability, total_pixels,
                    output ready);
endinterface

// configuration write channel
interface rgbhist_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rgbhist_pkg::CFG_IDX_W-1:0]   index;
    logic [rgbhist_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rgbhist_ram.sv =====
// generic single-port-write, registered-read ram
module rgbhist_ram #(
    parameter int WIDTH = rgbhist_pkg::COUNT_BITS,
    parameter int DEPTH = rgbhist_pkg::MAX_AXIS_BINS ** 3,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rgbhist_index.sv =====
// three-stage pipeline from pixel components to the flat red-major bin index
module rgbhist_index #(
    parameter int MAX_AXIS_BINS = rgbhist_pkg::MAX_AXIS_BINS,
    localparam int DEPTH = MAX_AXIS_BINS ** 3,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [rgbhist_pkg::COLOR_W-1:0]  red,
    input  logic [rgbhist_pkg::COLOR_W-1:0]  green,
    input  logic [rgbhist_pkg::COLOR_W-1:0]  blue,
    input  rgbhist_pkg::bins_cfg_t           bins_cfg,
    output logic                             done,
    output logic [IDX_W-1:0]                 idx
);

    localparam int BIN_W  = $clog2(MAX_AXIS_BINS + 1);
    localparam int PROD_W = rgbhist_pkg::COLOR_W + BIN_W;
    localparam int SQ     = MAX_AXIS_BINS * MAX_AXIS_BINS;
    localparam int ROW_W  = (SQ > 1) ? $clog2(SQ) : 1;
    localparam int RF_W   = 2 * BIN_W;
    localparam int IF_W   = ROW_W + BIN_W;

    // zero acts as one bin, anything past the maximum as the maximum
    function automatic logic [BIN_W-1:0] clamp_bins(input logic [rgbhist_pkg::CFG_W-1:0] v);
        logic [BIN_W-1:0] r;
        if (v == '0)
        begin
            r = BIN_W'(1);
        end
        else if (32'(v) > MAX_AXIS_BINS)
        begin
            r = BIN_W'(MAX_AXIS_BINS);
        end
        else
        begin
            r = BIN_W'(v);
        end
        return r;
    endfunction

    logic [BIN_W-1:0]  rb;
    logic [BIN_W-1:0]  gb;
    logic [BIN_W-1:0]  bb;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;
    logic [RF_W-1:0]   row_full;
    logic [IF_W-1:0]   idx_full;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [BIN_W-1:0]  rbin_reg;
    logic [BIN_W-1:0]  gbin_reg;
    logic [BIN_W-1:0]  bbin_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [BIN_W-1:0]  bbin2_reg;
    logic [IDX_W-1:0]  idx_reg;

    assign rb = clamp_bins(bins_cfg.red_split);
    assign gb = clamp_bins(bins_cfg.green_split);
    assign bb = clamp_bins(bins_cfg.blue_split);

    // stage 1: per-axis bin, floor(value * bins / 256)
    assign prod_r = PROD_W'(red) * PROD_W'(rb);
    assign prod_g = PROD_W'(green) * PROD_W'(gb);
    assign prod_b = PROD_W'(blue) * PROD_W'(bb);

    // stage 2: red-major row
    assign row_full = RF_W'(rbin_reg) * RF_W'(gb) + RF_W'(gbin_reg);

    // stage 3: full index
    assign idx_full = IF_W'(row_reg) * IF_W'(bb) + IF_W'(bbin2_reg);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        rbin_reg  <= prod_r[rgbhist_pkg::COLOR_W +: BIN_W];
        gbin_reg  <= prod_g[rgbhist_pkg::COLOR_W +: BIN_W];
        bbin_reg  <= prod_b[rgbhist_pkg::COLOR_W +: BIN_W];
        row_reg   <= row_full[ROW_W-1:0];
        bbin2_reg <= bbin_reg;
        idx_reg   <= idx_full[IDX_W-1:0];
    end

    assign done = v3_reg;
    assign idx  = idx_reg;

endmodule

// ===== hdl/rgbhist_div.sv =====
// bit-serial divider for count / total as a q1.16 fraction, saturating at one
module rgbhist_div #(
    parameter int WIDTH = rgbhist_pkg::COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [WIDTH-1:0]                num,
    input  logic [WIDTH-1:0]                den,
    output logic                            done,
    output logic [rgbhist_pkg::PROB_W-1:0]  quo
);

    localparam int CNT_W = $clog2(rgbhist_pkg::FRAC_BITS + 1);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [CNT_W-1:0]                     cnt_reg;
    logic [WIDTH-1:0]                     rem_reg;
    logic [rgbhist_pkg::FRAC_BITS-1:0]    q_reg;
    logic                                 full_reg;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;
    logic [WIDTH-1:0] rem_next;
    logic             at_least_one;

    // one quotient bit per cycle, remainder stays below the divisor
    assign shifted      = {rem_reg, 1'b0};
    assign diff         = shifted - {1'b0, den};
    assign fits         = shifted >= {1'b0, den};
    assign rem_next     = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    assign at_least_one = num >= den;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !at_least_one;
                done_reg <= at_least_one;
                cnt_reg  <= CNT_W'(rgbhist_pkg::FRAC_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            q_reg    <= '0;
            full_reg <= at_least_one;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[rgbhist_pkg::FRAC_BITS-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = full_reg ? rgbhist_pkg::PROB_ONE : {1'b0, q_reg};

endmodule

// ===== hdl/rgb_cube_histogram_backproject.sv =====
// top level of the rgb cube histogram with bin count and probability queries
//
// Pixels are binned per axis as floor(value * bins / 256) into a red-major flat
// index, and the counts live in one ram of MAX_AXIS_BINS^3 words with a
// registered read. After reset the block sweeps the ram to zero, one word per
// cycle, so pix.ready stays low until the sweep ends; configuration writes are
// taken throughout. Items are handled one at a time by a sequencer: accept, the
// index pipeline and the ram read; an accumulate item then ends with the
// read-modify-write of the bin, a raw query goes on to the result, and a
// normalized query first passes through the bit-serial divider unless the total
// is zero. A finished result sits in an output register, so the next item is
// accepted while the previous result waits to be taken. Item code 3 is accepted
// and dropped. Counts and the total saturate at COUNT_BITS.
module rgb_cube_histogram_backproject #(
    parameter int MAX_AXIS_BINS = rgbhist_pkg::MAX_AXIS_BINS,
    parameter int COUNT_BITS    = rgbhist_pkg::COUNT_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    rgbhist_pix_if.sink   pix,
    rgbhist_cfg_if.sink   cfg,
    rgbhist_res_if.source res
);

    localparam int DEPTH = MAX_AXIS_BINS ** 3;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(DEPTH - 1);

    // widen then cut to the fixed output width
    function automatic logic [rgbhist_pkg::COUNT_OUT_W-1:0] to_out(
        input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[rgbhist_pkg::COUNT_OUT_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    rgbhist_pkg::state_t     state_reg;
    rgbhist_pkg::state_t     state_next;
    rgbhist_pkg::bins_cfg_t  bins_cfg_reg;

    logic [IDX_W-1:0]                     clr_reg;
    logic [rgbhist_pkg::FUNC_W-1:0]       func_reg;
    logic [IDX_W-1:0]                     idx_reg;
    logic [COUNT_BITS-1:0]                count_reg;
    logic [rgbhist_pkg::PROB_W-1:0]       prob_reg;
    logic [COUNT_BITS-1:0]                total_reg;

    logic                                 res_valid_reg;
    logic [rgbhist_pkg::INDEX_OUT_W-1:0]  res_index_reg;
    logic [rgbhist_pkg::COUNT_OUT_W-1:0]  res_count_reg;
    logic [rgbhist_pkg::PROB_W-1:0]       res_prob_reg;
    logic [rgbhist_pkg::COUNT_OUT_W-1:0]  res_total_reg;

    logic                                 pix_ready;
    logic                                 pix_take;
    logic                                 idx_start;
    logic                                 idx_done;
    logic [IDX_W-1:0]                     idx_out;
    logic                                 ram_we;
    logic                                 ram_re;
    logic [IDX_W-1:0]                     ram_waddr;
    logic [COUNT_BITS-1:0]                ram_wdata;
    logic [COUNT_BITS-1:0]                ram_rdata;
    logic                                 div_start;
    logic                                 div_done;
    logic [rgbhist_pkg::PROB_W-1:0]       div_quo;
    logic                                 res_free;
    logic                                 res_load;
    logic                                 is_accum;
    logic                                 want_div;
    logic [31:0]                          idx_wide;

    assign pix_take = pix.valid && pix_ready;
    assign res_free = !res_valid_reg || res.ready;
    assign is_accum = func_reg == rgbhist_pkg::FUNC_ACCUM;
    assign want_div = (func_reg == rgbhist_pkg::FUNC_PROB) && (total_reg != '0);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_cfg_reg.red_split   <= rgbhist_pkg::BIN_RESET;
            bins_cfg_reg.green_split <= rgbhist_pkg::BIN_RESET;
            bins_cfg_reg.blue_split  <= rgbhist_pkg::BIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rgbhist_pkg::CFG_RED:   bins_cfg_reg.red_split   <= cfg.data;
                rgbhist_pkg::CFG_GREEN: bins_cfg_reg.green_split <= cfg.data;
                rgbhist_pkg::CFG_BLUE:  bins_cfg_reg.blue_split  <= cfg.data;
                default:                bins_cfg_reg             <= bins_cfg_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rgbhist_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = rgbhist_pkg::ST_IDLE;
                end
            end
            rgbhist_pkg::ST_IDLE:
            begin
                if (pix_take && pix.func != rgbhist_pkg::FUNC_NONE)
                begin
                    state_next = rgbhist_pkg::ST_INDEX;
                end
            end
            rgbhist_pkg::ST_INDEX:
            begin
                if (idx_done)
                begin
                    state_next = rgbhist_pkg::ST_DATA;
                end
            end
            rgbhist_pkg::ST_DATA:
            begin
                if (is_accum)
                begin
                    state_next = rgbhist_pkg::ST_IDLE;
                end
                else if (want_div)
                begin
                    state_next = rgbhist_pkg::ST_DIV;
                end
                else
                begin
                    state_next = rgbhist_pkg::ST_RESULT;
                end
            end
            rgbhist_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = rgbhist_pkg::ST_RESULT;
                end
            end
            rgbhist_pkg::ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = rgbhist_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgbhist_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pix_ready = 1'b0;
        idx_start = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = sat_inc(ram_rdata);
        div_start = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            rgbhist_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            rgbhist_pkg::ST_IDLE:
            begin
                pix_ready = 1'b1;
                idx_start = pix.valid && pix.func != rgbhist_pkg::FUNC_NONE;
            end
            rgbhist_pkg::ST_INDEX:
            begin
                ram_re = idx_done;
            end
            rgbhist_pkg::ST_DATA:
            begin
                ram_we    = is_accum;
                div_start = want_div;
            end
            rgbhist_pkg::ST_RESULT:
            begin
                res_load = res_free;
            end
            default:
            begin
                pix_ready = 1'b0;
            end
        endcase
    end

    assign pix.ready = pix_ready;

    // state and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgbhist_pkg::ST_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rgbhist_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (state_reg == rgbhist_pkg::ST_DATA && is_accum)
            begin
                total_reg <= sat_inc(total_reg);
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            func_reg <= pix.func;
        end
        if (ram_re)
        begin
            idx_reg <= idx_out;
        end
        if (state_reg == rgbhist_pkg::ST_DATA)
        begin
            count_reg <= ram_rdata;
            prob_reg  <= '0;
        end
        else if (state_reg == rgbhist_pkg::ST_DIV && div_done)
        begin
            prob_reg <= div_quo;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign idx_wide = 32'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_index_reg <= idx_wide[rgbhist_pkg::INDEX_OUT_W-1:0];
            res_count_reg <= to_out(count_reg);
            res_prob_reg  <= prob_reg;
            res_total_reg <= to_out(total_reg);
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.bin_index    = res_index_reg;
    assign res.bin_count    = res_count_reg;
    assign res.probability  = res_prob_reg;
    assign res.total_pixels = res_total_reg;

    // bin index pipeline
    rgbhist_index #(
        .MAX_AXIS_BINS (MAX_AXIS_BINS)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (idx_start),
        .red      (pix.red),
        .green    (pix.green),
        .blue     (pix.blue),
        .bins_cfg (bins_cfg_reg),
        .done     (idx_done),
        .idx      (idx_out)
    );

    // bin count store
    rgbhist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_out),
        .rdata (ram_rdata)
    );

    // probability divider, numerator straight from the store read
    rgbhist_div #(
        .WIDTH (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (ram_rdata),
        .den   (total_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // read and write of the store never coincide
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_re && ram_we))
        else $error("store read and write in the same cycle");

    // the pixel total never goes backward
    assert property (@(posedge clk) disable iff (!rst_n) total_reg >= $past(total_reg))
        else $error("pixel total decreased");

    // a probability never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> div_quo <= rgbhist_pkg::PROB_ONE)
        else $error("probability above one");

    // a meaningful item always starts the index pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_take && pix.func != rgbhist_pkg::FUNC_NONE
        |=> state_reg == rgbhist_pkg::ST_INDEX)
        else $error("accepted item did not enter indexing");

endmodule

// ===== bench/rgbhist_checker.sv =====
// histogram checker: keeps its own copy of the bin store, predicts query answers, compares
module rgbhist_checker
    import rgbhist_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rgbhist_pix_if pix,
    rgbhist_cfg_if cfg,
    rgbhist_res_if res,
    output int     fail_count,
    output int     pending,
    output int     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_AXIS_BINS * MAX_AXIS_BINS * MAX_AXIS_BINS;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
    localparam int PRINT_CAP = 40;

    // one answer as the block should present it
    typedef struct packed {
        logic [INDEX_OUT_W-1:0] bin_index;
        logic [COUNT_OUT_W-1:0] bin_count;
        logic [PROB_W-1:0]      probability;
        logic [COUNT_OUT_W-1:0] total_pixels;
    } answer_t;

    logic [CFG_W-1:0]      red_setting;
    logic [CFG_W-1:0]      green_setting;
    logic [CFG_W-1:0]      blue_setting;
    logic [COUNT_BITS-1:0] bin_store [STORE_DEPTH];
    logic [COUNT_BITS-1:0] pixels_seen;
    answer_t               answers_due [$];

    // register value to usable bins: zero acts as one, too large clamps
    function automatic int unsigned axis_span(input logic [CFG_W-1:0] setting);
        if (setting == '0)
            return 1;
        if (setting > MAX_AXIS_BINS)
            return MAX_AXIS_BINS;
        return 32'(setting);
    endfunction

    // red-major flat bin of a pixel under the current settings
    function automatic int unsigned flat_bin(input logic [COLOR_W-1:0] r, g, b);
        int unsigned rb, gb, bb, ri, gi, bi, idx;
        rb  = axis_span(red_setting);
        gb  = axis_span(green_setting);
        bb  = axis_span(blue_setting);
        ri  = (32'(r) * rb) >> COLOR_W;
        gi  = (32'(g) * gb) >> COLOR_W;
        bi  = (32'(b) * bb) >> COLOR_W;
        idx = (ri * gb + gi) * bb + bi;
        if (idx >= STORE_DEPTH)
            idx = STORE_DEPTH - 1;
        return idx;
    endfunction

    // count over total in q1.16, truncated, zero on an empty histogram
    function automatic logic [PROB_W-1:0] share_q16(input logic [COUNT_BITS-1:0] count,
                                                   input logic [COUNT_BITS-1:0] total);
        logic [63:0] quotient;
        if (total == '0)
            return '0;
        quotient = (64'(count) << FRAC_BITS) / 64'(total);
        if (quotient > 64'(PROB_ONE))
            quotient = 64'(PROB_ONE);
        return quotient[PROB_W-1:0];
    endfunction

    task automatic report(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // watch all three channels; answers leave before new items arrive
    always @(posedge clk or negedge rst_n)
    begin
        answer_t     want;
        int unsigned idx;
        if (!rst_n)
        begin
            red_setting   = BIN_RESET;
            green_setting = BIN_RESET;
            blue_setting  = BIN_RESET;
            for (int i = 0; i < STORE_DEPTH; i++)
                bin_store[i] = '0;
            pixels_seen = '0;
            answers_due.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // compare a taken result with the oldest answer due
            if (res.valid && res.ready)
            begin
                if (answers_due.size() == 0)
                    report($sformatf("result for bin %0d with no query outstanding",
                                     res.bin_index));
                else
                begin
                    want = answers_due.pop_front();
                    if (res.bin_index !== want.bin_index)
                        report($sformatf("bin_index got %0d expected %0d",
                                         res.bin_index, want.bin_index));
                    if (res.bin_count !== want.bin_count)
                        report($sformatf("bin_count of bin %0d got %0d expected %0d",
                                         want.bin_index, res.bin_count, want.bin_count));
                    if (res.probability !== want.probability)
                        report($sformatf("probability of bin %0d got %0d expected %0d",
                                         want.bin_index, res.probability, want.probability));
                    if (res.total_pixels !== want.total_pixels)
                        report($sformatf("total_pixels got %0d expected %0d",
                                         res.total_pixels, want.total_pixels));
                    checked++;
                end
            end

            // register writes; the spare index is ignored
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_RED:   red_setting   = cfg.data;
                    CFG_GREEN: green_setting = cfg.data;
                    CFG_BLUE:  blue_setting  = cfg.data;
                    default:   ;
                endcase
            end

            // pixel items update the store or queue an answer
            if (pix.valid && pix.ready)
            begin
                idx = flat_bin(pix.red, pix.green, pix.blue);
                case (pix.func)
                    FUNC_ACCUM:
                    begin
                        if (bin_store[idx] != COUNT_TOP)
                            bin_store[idx]++;
                        if (pixels_seen != COUNT_TOP)
                            pixels_seen++;
                    end
                    FUNC_RAW, FUNC_PROB:
                    begin
                        want.bin_index    = idx[INDEX_OUT_W-1:0];
                        want.bin_count    = COUNT_OUT_W'(bin_store[idx]);
                        want.probability  = (pix.func == FUNC_PROB) ?
                                            share_q16(bin_store[idx], pixels_seen) : '0;
                        want.total_pixels = COUNT_OUT_W'(pixels_seen);
                        answers_due.push_back(want);
                    end
                    default: ;
                endcase
            end
            pending = answers_due.size();
        end
    end

endmodule

// ===== bench/rgb_cube_histogram_backproject_tb.sv =====
// top of the histogram bench: clock, reset, pixel and register stimulus, output stalls, verdict
module rgb_cube_histogram_backproject_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhist_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count;
    int   pix_gap_pct;
    int   res_stall_pct;
    bit   hold_req;
    int   n_accum;
    int   n_raw;
    int   n_prob;
    int   n_ignored;
    int   n_settings;
    logic [3*COLOR_W-1:0] hot_pixels [8];

    rgbhist_pix_if pix_ch ();
    rgbhist_cfg_if cfg_ch ();
    rgbhist_res_if res_ch ();

    rgb_cube_histogram_backproject dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    rgbhist_checker hist_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_ch),
        .cfg        (cfg_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding", cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < res_stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    // offer one pixel item and wait until it is taken
    task automatic send_pixel(input logic [FUNC_W-1:0] f, input logic [COLOR_W-1:0] r, g, b);
        int unsigned gap;
        if ($urandom_range(0, 99) < pix_gap_pct)
        begin
            gap = pick_gap();
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.func  <= f;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        case (f)
            FUNC_ACCUM: n_accum++;
            FUNC_RAW:   n_raw++;
            FUNC_PROB:  n_prob++;
            default:    n_ignored++;
        endcase
    endtask

    // one register write, valid left high for a following write
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // drain every answer, then let a trailing accumulate finish
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel mix: repeated hot pixels, corners, bin edges, anything
    task automatic pick_pixel(output logic [COLOR_W-1:0] r, g, b);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            {r, g, b} = hot_pixels[$urandom_range(0, 7)];
        else if (roll < 55)
        begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 2) == 0 ? COLOR_W'($urandom) :
                ($urandom_range(0, 1) ? 8'hFF : 8'h00);
        end
        else if (roll < 70)
        begin
            r = {4'($urandom_range(0, 15)), 4'h0} - 8'($urandom_range(0, 1));
            g = {4'($urandom_range(0, 15)), 4'h0} - 8'($urandom_range(0, 1));
            b = {4'($urandom_range(0, 15)), 4'h0} - 8'($urandom_range(0, 1));
        end
        else
            {r, g, b} = 24'($urandom);
    endtask

    // new bin settings, then a stretch of random pixel traffic
    task automatic run_phase(input logic [CFG_W-1:0] r_bins, g_bins, b_bins,
                             input int n_items, input int gap_pct, input int stall_pct,
                             input bit with_hold);
        logic [FUNC_W-1:0]  f;
        logic [COLOR_W-1:0] r, g, b;
        int                 roll;
        wait_idle();
        write_setting(CFG_SPARE, CFG_W'($urandom));
        write_setting(CFG_RED, r_bins);
        write_setting(CFG_GREEN, g_bins);
        write_setting(CFG_BLUE, b_bins);
        cfg_ch.valid <= 1'b0;
        n_settings++;
        pix_gap_pct   = gap_pct;
        res_stall_pct = stall_pct;
        for (int i = 0; i < 8; i++)
            hot_pixels[i] = 24'($urandom);
        for (int n = 0; n < n_items; n++)
        begin
            if (with_hold && n == 20)
                hold_req = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                f = FUNC_ACCUM;
            else if (roll < 70)
                f = FUNC_RAW;
            else if (roll < 95)
                f = FUNC_PROB;
            else
                f = FUNC_NONE;
            pick_pixel(r, g, b);
            send_pixel(f, r, g, b);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        cycle_count   = 0;
        pix_gap_pct   = 20;
        res_stall_pct = 20;
        hold_req      = 1'b0;
        n_accum       = 0;
        n_raw         = 0;
        n_prob        = 0;
        n_ignored     = 0;
        n_settings    = 1;
        rst_n        <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.func  <= FUNC_ACCUM;
        pix_ch.red   <= '0;
        pix_ch.green <= '0;
        pix_ch.blue  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_RED;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed at reset bins: empty histogram, single bin, corners, ignored code
        send_pixel(FUNC_PROB,  8'd0,   8'd0,   8'd0);
        send_pixel(FUNC_RAW,   8'd255, 8'd255, 8'd255);
        send_pixel(FUNC_ACCUM, 8'd5,   8'd6,   8'd7);
        send_pixel(FUNC_ACCUM, 8'd31,  8'd31,  8'd31);
        send_pixel(FUNC_PROB,  8'd0,   8'd0,   8'd0);
        send_pixel(FUNC_ACCUM, 8'd255, 8'd255, 8'd255);
        send_pixel(FUNC_ACCUM, 8'd255, 8'd0,   8'd255);
        send_pixel(FUNC_ACCUM, 8'd0,   8'd255, 8'd0);
        send_pixel(FUNC_ACCUM, 8'd32,  8'd32,  8'd32);
        send_pixel(FUNC_NONE,  8'd0,   8'd0,   8'd0);
        send_pixel(FUNC_RAW,   8'd0,   8'd0,   8'd0);
        send_pixel(FUNC_PROB,  8'd0,   8'd0,   8'd0);
        send_pixel(FUNC_PROB,  8'd255, 8'd255, 8'd255);
        send_pixel(FUNC_RAW,   8'd255, 8'd0,   8'd255);
        send_pixel(FUNC_PROB,  8'd224, 8'd223, 8'd32);
        send_pixel(FUNC_NONE,  8'd255, 8'd255, 8'd255);
        send_pixel(FUNC_RAW,   8'd128, 8'd64,  8'd200);

        // bin settings: largest, smallest, out of range with a hold-off, mixed, random
        run_phase(5'd16, 5'd16, 5'd16, 168, 30, 30, 1'b0);
        run_phase(5'd1,  5'd1,  5'd1,  168, 0,  0,  1'b0);
        run_phase(5'd0,  5'd31, 5'd17, 168, 30, 40, 1'b1);
        run_phase(5'd3,  5'd5,  5'd7,  168, 50, 20, 1'b0);
        run_phase(5'd16, 5'd1,  5'd16, 168, 10, 60, 1'b0);
        for (int k = 0; k < 3; k++)
            run_phase(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)),
                      CFG_W'($urandom_range(0, 31)), 168, 25, 25, 1'b0);
        wait_idle();

        $display("pixel items: %0d accumulate, %0d raw query, %0d normalized query, %0d ignored",
                 n_accum, n_raw, n_prob, n_ignored);
        $display("%0d answers checked across %0d bin settings, with one %0d-cycle output hold",
                 checked, n_settings, HOLD_CYCLES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== rgb_cube_histogram_backproject.f =====
hdl/rgbhist_pkg.sv
hdl/rgbhist_if.sv
hdl/rgbhist_ram.sv
hdl/rgbhist_index.sv
hdl/rgbhist_div.sv
hdl/rgb_cube_histogram_backproject.sv
bench/rgbhist_checker.sv
bench/rgb_cube_histogram_backproject_tb.sv
